/* src/assert_macros.svh */
// Assertion macros used by the top level of the 3x3 inverse block.
// Plain text macros only; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define MIA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> cons) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define MIA_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* src/mia_pkg.sv */
// Package for the 3x3 adjugate inverse block: widths, types, latency.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package mia_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int EPS_BITS  = 31;

    // Exact intermediate widths
    localparam int PROD_W  = 2 * WORD_BITS;
    localparam int COF_W   = 2 * WORD_BITS + 1;
    localparam int DET_W   = 3 * WORD_BITS + 3;
    localparam int NUM_RAW = 2 * WORD_BITS + 2 * FRAC_BITS + 2;
    localparam int NUM_W   = ((NUM_RAW > DET_W) ? NUM_RAW : DET_W) + 1;
    localparam int DIV_W   = DET_W + 1;
    localparam int CMP_W   = ((NUM_W > DIV_W + WORD_BITS) ? NUM_W : DIV_W + WORD_BITS) + 1;
    localparam int EPSC_W  = (DET_W > EPS_BITS + 2 * FRAC_BITS) ?
                             DET_W : EPS_BITS + 2 * FRAC_BITS;

    // Pipeline depth: cofactors 2, determinant 4, divider WORD_BITS + 2, output 1
    localparam int VLD_LEN = WORD_BITS + 8;
    localparam int LATENCY = WORD_BITS + 9;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic [8:0][WORD_BITS-1:0]   mat_t;
    typedef logic [2:0][WORD_BITS-1:0]   row_t;
    typedef logic [8:0][COF_W-1:0]       cof_arr_t;

    typedef struct packed {
        logic [DET_W-1:0] mag;
        logic             neg;
        logic             singular;
    } det_info_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] value;
        logic                 ovf;
    } lane_res_t;

endpackage

/* src/mat3_inverse_adjugate.sv */
// Top level of the 3x3 matrix inverse by the adjugate.
// Depends on mia_pkg, mia_cofactor, mia_det, mia_div_lane, assert_macros.svh.
`timescale 1ns / 1ps
//
// Usage:
//  - Request: pulse start with m00..m22 (signed Q16.16). busy is always low,
//    so a new matrix may be issued on every clock cycle.
//  - Result: done is high for one cycle with inv00..inv22, singular and
//    overflow. The receiver cannot stall; results are never held back.
//  - Throughput: one matrix per cycle. A request passes the cofactor,
//    determinant and divider stages and the output register to done; the
//    nine divider lanes retire one quotient bit per pipeline stage.
//  - Singular: |det| <= singular_epsilon gives zero outputs, singular high.
//  - Configuration: cfg_valid/cfg_data write singular_epsilon; cfg_ready is
//    always high. Write it only with no request in flight.
//  - Reset: rst_n (async, active low) drops all in-flight requests and sets
//    singular_epsilon to 1.
//

`include "assert_macros.svh"

module mat3_inverse_adjugate (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  mia_pkg::word_t                m00,
    input  mia_pkg::word_t                m01,
    input  mia_pkg::word_t                m02,
    input  mia_pkg::word_t                m10,
    input  mia_pkg::word_t                m11,
    input  mia_pkg::word_t                m12,
    input  mia_pkg::word_t                m20,
    input  mia_pkg::word_t                m21,
    input  mia_pkg::word_t                m22,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mia_pkg::EPS_BITS-1:0]  cfg_data,
    output logic                          done,
    output mia_pkg::word_t                inv00,
    output mia_pkg::word_t                inv01,
    output mia_pkg::word_t                inv02,
    output mia_pkg::word_t                inv10,
    output mia_pkg::word_t                inv11,
    output mia_pkg::word_t                inv12,
    output mia_pkg::word_t                inv20,
    output mia_pkg::word_t                inv21,
    output mia_pkg::word_t                inv22,
    output logic                          singular,
    output logic                          overflow
);
    import mia_pkg::*;

    mat_t                 mat;
    cof_arr_t             cof;
    row_t                 row0;
    det_info_t            info;
    cof_arr_t             cof_dly_reg [4];
    lane_res_t            lane_res [9];

    logic [EPS_BITS-1:0]  eps_reg;
    logic [VLD_LEN-1:0]   vld_reg;
    logic [WORD_BITS+1:0] sing_reg;
    logic                 done_reg;
    logic [WORD_BITS-1:0] inv_reg [9];
    logic                 singular_reg;
    logic                 overflow_reg;
    logic                 ovf_any;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign mat       = {m22, m21, m20, m12, m11, m10, m02, m01, m00};

    // Threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= EPS_BITS'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            eps_reg <= cfg_data;
        end
    end

    mia_cofactor u_cofactor (
        .clk  (clk),
        .mat  (mat),
        .cof  (cof),
        .row0 (row0)
    );

    mia_det u_det (
        .clk  (clk),
        .cof  (cof),
        .row0 (row0),
        .eps  (eps_reg),
        .info (info)
    );

    // Hold cofactors until the determinant is ready
    always_ff @(posedge clk)
    begin
        cof_dly_reg[0] <= cof;
        cof_dly_reg[1] <= cof_dly_reg[0];
        cof_dly_reg[2] <= cof_dly_reg[1];
        cof_dly_reg[3] <= cof_dly_reg[2];
    end

    // Nine divider lanes, lane (i,j) takes cofactor (j,i)
    for (genvar k = 0; k < 9; k++)
    begin : g_lane
        mia_div_lane u_lane (
            .clk  (clk),
            .cof  (cof_dly_reg[3][(k%3)*3 + k/3]),
            .info (info),
            .res  (lane_res[k])
        );
    end

    // Request tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[VLD_LEN-2:0], start && !busy};
            done_reg <= vld_reg[VLD_LEN-1];
        end
    end

    // Singular flag travels beside the lanes
    always_ff @(posedge clk)
    begin
        sing_reg <= {sing_reg[WORD_BITS:0], info.singular};
    end

    // Merge lane results into the output register
    always_comb
    begin
        ovf_any = 1'b0;
        for (int k = 0; k < 9; k++)
        begin
            ovf_any = ovf_any | lane_res[k].ovf;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 9; k++)
        begin
            inv_reg[k] <= sing_reg[WORD_BITS+1] ? '0 : lane_res[k].value;
        end
        singular_reg <= sing_reg[WORD_BITS+1];
        overflow_reg <= !sing_reg[WORD_BITS+1] && ovf_any;
    end

    assign done     = done_reg;
    assign inv00    = inv_reg[0];
    assign inv01    = inv_reg[1];
    assign inv02    = inv_reg[2];
    assign inv10    = inv_reg[3];
    assign inv11    = inv_reg[4];
    assign inv12    = inv_reg[5];
    assign inv20    = inv_reg[6];
    assign inv21    = inv_reg[7];
    assign inv22    = inv_reg[8];
    assign singular = singular_reg;
    assign overflow = overflow_reg;

    // Checks
    `MIA_ASSERT_IMP(a_latency, clk, rst_n, start && !busy, ##LATENCY done)
    `MIA_ASSERT_IMP(a_sing_zero, clk, rst_n, done && singular, !overflow && inv11 == 0)
    `MIA_ASSERT_NXT(a_cfg_write, clk, rst_n, cfg_valid, eps_reg == $past(cfg_data))

endmodule

/* src/mia_cofactor.sv */
// Cofactor stage: 18 registered products, then nine registered cross differences.
// Depends on mia_pkg.
`timescale 1ns / 1ps

module mia_cofactor (
    input  logic              clk,
    input  mia_pkg::mat_t     mat,
    output mia_pkg::cof_arr_t cof,
    output mia_pkg::row_t     row0
);
    import mia_pkg::*;

    logic signed [PROD_W-1:0] pa_reg [9];
    logic signed [PROD_W-1:0] pb_reg [9];
    row_t                     row_d1_reg;
    row_t                     row_d2_reg;
    cof_arr_t                 cof_reg;

    // Products with cyclic row and column indices
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                pa_reg[i*3+j] <= $signed(mat[((i+1)%3)*3 + (j+1)%3])
                               * $signed(mat[((i+2)%3)*3 + (j+2)%3]);
                pb_reg[i*3+j] <= $signed(mat[((i+1)%3)*3 + (j+2)%3])
                               * $signed(mat[((i+2)%3)*3 + (j+1)%3]);
            end
        end
        row_d1_reg <= mat[2:0];
    end

    // Exact differences
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 9; k++)
        begin
            cof_reg[k] <= $signed({pa_reg[k][PROD_W-1], pa_reg[k]})
                        - $signed({pb_reg[k][PROD_W-1], pb_reg[k]});
        end
        row_d2_reg <= row_d1_reg;
    end

    assign cof  = cof_reg;
    assign row0 = row_d2_reg;

endmodule

/* src/mia_det.sv */
// Determinant merge: first cofactor row dotted with the first matrix row,
// split products, sum, magnitude and singular test. Uses mia_pkg.
`timescale 1ns / 1ps

module mia_det (
    input  logic                           clk,
    input  mia_pkg::cof_arr_t              cof,
    input  mia_pkg::row_t                  row0,
    input  logic [mia_pkg::EPS_BITS-1:0]   eps,
    output mia_pkg::det_info_t             info
);
    import mia_pkg::*;

    logic signed [COF_W-1:0] hi_reg [3];
    logic signed [COF_W-1:0] lo_reg [3];
    logic signed [DET_W-1:0] term_reg [3];
    logic signed [DET_W-1:0] det_reg;
    logic [DET_W-1:0]        det_abs;
    logic [EPSC_W-1:0]       eps_ext;
    det_info_t               info_reg;

    // Partial products: upper part signed, lower word unsigned
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 3; j++)
        begin
            hi_reg[j] <= $signed(cof[j][COF_W-1:WORD_BITS]) * $signed(row0[j]);
            lo_reg[j] <= $signed({1'b0, cof[j][WORD_BITS-1:0]}) * $signed(row0[j]);
        end
    end

    // Recombine each term
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 3; j++)
        begin
            term_reg[j] <= (DET_W'(hi_reg[j]) <<< WORD_BITS) + DET_W'(lo_reg[j]);
        end
    end

    // Sum of the three terms
    always_ff @(posedge clk)
    begin
        det_reg <= term_reg[0] + term_reg[1] + term_reg[2];
    end

    // Magnitude and threshold compare
    always_comb
    begin
        det_abs = det_reg[DET_W-1] ? DET_W'(-det_reg) : det_reg;
        eps_ext = EPSC_W'({eps, {(2*FRAC_BITS){1'b0}}});
    end

    always_ff @(posedge clk)
    begin
        info_reg.mag      <= det_abs;
        info_reg.neg      <= det_reg[DET_W-1];
        info_reg.singular <= EPSC_W'(det_abs) <= eps_ext;
    end

    assign info = info_reg;

endmodule

/* src/mia_div_lane.sv */
// One divider lane: rounded, saturated quotient of one cofactor by the
// determinant, one quotient bit per stage. Uses mia_pkg.
`timescale 1ns / 1ps

module mia_div_lane (
    input  logic                            clk,
    input  logic [mia_pkg::COF_W-1:0]       cof,
    input  mia_pkg::det_info_t              info,
    output mia_pkg::lane_res_t              res
);
    import mia_pkg::*;

    logic [COF_W-1:0]     cmag;
    logic [NUM_W-1:0]     num_p_reg;
    logic [DIV_W-1:0]     d_p_reg;
    logic                 neg_p_reg;

    logic [CMP_W-1:0]     rem_reg [WORD_BITS];
    logic [DIV_W-1:0]     d_reg   [WORD_BITS];
    logic [WORD_BITS-1:0] q_reg   [WORD_BITS+1];
    logic                 big_reg [WORD_BITS+1];
    logic                 neg_reg [WORD_BITS+1];

    logic [WORD_BITS-1:0] q_fin;
    logic [WORD_BITS-1:0] lim;
    logic [WORD_BITS-1:0] sat;
    logic                 ovf;

    // Numerator 2|c|*2^(2F) + |det| and divisor 2|det|, rounds half away
    assign cmag = cof[COF_W-1] ? COF_W'(-$signed(cof)) : cof;

    always_ff @(posedge clk)
    begin
        num_p_reg <= (NUM_W'(cmag) << (2*FRAC_BITS + 1)) + NUM_W'(info.mag);
        d_p_reg   <= {info.mag, 1'b0};
        neg_p_reg <= cof[COF_W-1] ^ info.neg;
    end

    // Flag when the quotient cannot fit the word
    always_ff @(posedge clk)
    begin
        rem_reg[0] <= CMP_W'(num_p_reg);
        d_reg[0]   <= d_p_reg;
        q_reg[0]   <= '0;
        big_reg[0] <= CMP_W'(num_p_reg) >= (CMP_W'(d_p_reg) << WORD_BITS);
        neg_reg[0] <= neg_p_reg;
    end

    // Restoring division, MSB first
    for (genvar k = 0; k < WORD_BITS; k++)
    begin : g_bit
        localparam int B = WORD_BITS - 1 - k;
        logic [CMP_W-1:0] dsh;
        logic             ge;

        assign dsh = CMP_W'(d_reg[k]) << B;
        assign ge  = rem_reg[k] >= dsh;

        always_ff @(posedge clk)
        begin
            q_reg[k+1]   <= q_reg[k] | (WORD_BITS'(ge) << B);
            big_reg[k+1] <= big_reg[k];
            neg_reg[k+1] <= neg_reg[k];
        end

        if (k < WORD_BITS - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                rem_reg[k+1] <= ge ? rem_reg[k] - dsh : rem_reg[k];
                d_reg[k+1]   <= d_reg[k];
            end
        end
    end

    // Saturate and apply sign
    always_comb
    begin
        q_fin     = q_reg[WORD_BITS];
        lim       = neg_reg[WORD_BITS] ? {1'b1, {(WORD_BITS-1){1'b0}}}
                                       : {1'b0, {(WORD_BITS-1){1'b1}}};
        ovf       = big_reg[WORD_BITS] || (q_fin > lim);
        sat       = ovf ? lim : q_fin;
        res.value = neg_reg[WORD_BITS] ? WORD_BITS'(-sat) : sat;
        res.ovf   = ovf;
    end

endmodule
